>>> src/ledscan_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and color helpers for the led panel scan driver
package ledscan_pkg;

  // item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_RGB888 = 2'd0,
    KIND_RGB565 = 2'd1,
    KIND_SCAN   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // rgb565 widening constants
  localparam int unsigned Exp5Mul = 527;
  localparam int unsigned Exp5Add = 23;
  localparam int unsigned Exp6Mul = 259;
  localparam int unsigned Exp6Add = 33;

  localparam logic [15:0] BaseOnTimeReset = 16'd1;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [15:0]        packed_color;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  row_select;
    logic [7:0]  shift_byte;
    logic [1:0]  plane_index;
    logic [18:0] on_time;
    logic        last_of_row;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rmw_rd;
    logic rmw_wr;
    logic scan_rd;
    logic clr_wr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic coord_ok;
    logic rmw_last;
    logic scan_last;
    logic clr_last;
    logic can_issue;
  } sts_t;

  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [13:0] w;
    w = 14'(v) * 14'(Exp5Mul) + 14'(Exp5Add);
    return w[13:6];
  endfunction

  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [13:0] w;
    w = 14'(v) * 14'(Exp6Mul) + 14'(Exp6Add);
    return w[13:6];
  endfunction

endpackage

>>> src/ledscan_ram.sv
`timescale 1ns / 1ps
// generic single write port, single read port ram with registered read
module ledscan_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 3072
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ledscan_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine for pixel writes, scans and clears
module ledscan_ctrl
  import ledscan_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  kind_e kind_i,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RMW_RD = 5'b00010,
    ST_RMW_WR = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_CLEAR  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (kind_i) inside
            KIND_RGB888, KIND_RGB565: begin
              if (sts_i.coord_ok) begin
                state_d = ST_RMW_RD;
              end
            end
            KIND_SCAN:  state_d = ST_SCAN;
            KIND_CLEAR: state_d = ST_CLEAR;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_RMW_RD: begin
        cmd_o.rmw_rd = 1'b1;
        state_d      = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        cmd_o.rmw_wr = 1'b1;
        state_d      = sts_i.rmw_last ? ST_IDLE : ST_RMW_RD;
      end
      ST_SCAN: begin
        if (sts_i.can_issue) begin
          cmd_o.scan_rd = 1'b1;
          if (sts_i.scan_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // reset starts with a sweep that zeroes the frame store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/ledscan_dp.sv
`timescale 1ns / 1ps
// frame store, address generation, bit plane update and output staging
module ledscan_dp
  import ledscan_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 64,
  parameter int unsigned PANEL_HEIGHT = 32,
  parameter int unsigned BIT_PLANES   = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  output sts_t      sts_o,
  input  in_item_t  in_data_i,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  localparam int unsigned RowBytes   = PANEL_WIDTH / 8;
  localparam int unsigned Groups     = PANEL_HEIGHT / 2;
  localparam int unsigned GroupBytes = 3 * 2 * RowBytes;
  localparam int unsigned PlaneBytes = Groups * GroupBytes;
  localparam int unsigned StoreBytes = BIT_PLANES * PlaneBytes;
  localparam int unsigned ColorStep  = 2 * RowBytes;
  localparam int unsigned PlaneStep  = PlaneBytes - 2 * ColorStep;
  localparam int unsigned DropBits   = 8 - BIT_PLANES;
  localparam int unsigned AW = $clog2(StoreBytes);
  localparam int unsigned KW = $clog2(GroupBytes);
  localparam int unsigned RW = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned PW = (BIT_PLANES > 1) ? $clog2(BIT_PLANES) : 1;
  localparam int unsigned XW = $clog2(PANEL_WIDTH);
  localparam int unsigned YW = $clog2(PANEL_HEIGHT);
  localparam logic [1:0] LastColor = 2'd2;

  // control state
  logic [AW-1:0] addr_q, addr_d;
  logic [1:0]    c_q, c_d;
  logic [PW-1:0] p_q, p_d;
  logic [KW-1:0] k_q, k_d;
  logic [RW-1:0] row_q, row_d;
  logic [PW-1:0] plane_q, plane_d;
  logic [15:0]   base_q;
  logic          pend_q;
  logic          out_v_q, out_v_d;
  logic          skid_v_q, skid_v_d;

  // payload
  logic [2:0][BIT_PLANES-1:0] cols_q, cols_d;
  logic [2:0]  bit_q;
  logic [3:0]  meta_row_q;
  logic [1:0]  meta_plane_q;
  logic [18:0] meta_ont_q;
  out_item_t   pend_item_q, pend_item_d;
  out_item_t   out_q, out_d;
  out_item_t   skid_q, skid_d;
  out_item_t   arrive;

  // pixel decode
  logic          x_ok, y_ok, lower;
  logic [XW-1:0] mx;
  logic [YW-1:0] y_lo;
  logic [RW-1:0] grp;
  logic [AW-1:0] byte_idx, wr_start, scan_start;
  logic [7:0]    r8, g8, b8;
  logic          row_last;

  // ram
  logic          ram_we, ram_re;
  logic [7:0]    ram_wdata, ram_rdata, mask;
  logic          set_bit;
  logic [1:0]    occ;
  logic          leave, out_free;

  always_comb begin
    x_ok = !in_data_i.pos_x[15] && (in_data_i.pos_x[14:0] < 15'(PANEL_WIDTH));
    y_ok = !in_data_i.pos_y[15] && (in_data_i.pos_y[14:0] < 15'(PANEL_HEIGHT));
    // mirrored column
    mx       = XW'(PANEL_WIDTH - 1) - in_data_i.pos_x[XW-1:0];
    byte_idx = AW'(RowBytes - 1) - AW'(mx >> 3);
    y_lo     = in_data_i.pos_y[YW-1:0];
    lower    = (y_lo >= YW'(Groups));
    grp      = lower ? RW'(y_lo - YW'(Groups)) : RW'(y_lo);
    wr_start = AW'(grp) * AW'(GroupBytes) + (lower ? AW'(0) : AW'(RowBytes)) + byte_idx;
    scan_start = AW'(plane_q) * AW'(PlaneBytes) + AW'(row_q) * AW'(GroupBytes);
    if (in_data_i.kind == KIND_RGB565) begin
      r8 = expand5(in_data_i.packed_color[15:11]);
      g8 = expand6(in_data_i.packed_color[10:5]);
      b8 = expand5(in_data_i.packed_color[4:0]);
    end else begin
      r8 = in_data_i.red_in;
      g8 = in_data_i.green_in;
      b8 = in_data_i.blue_in;
    end
    cols_d[0] = BIT_PLANES'(b8 >> DropBits);
    cols_d[1] = BIT_PLANES'(g8 >> DropBits);
    cols_d[2] = BIT_PLANES'(r8 >> DropBits);
    row_last  = (row_q == RW'(Groups - 1));
  end

  // address and counter sequencing
  always_comb begin
    addr_d  = addr_q;
    c_d     = c_q;
    p_d     = p_q;
    k_d     = k_q;
    row_d   = row_q;
    plane_d = plane_q;
    if (cmd_i.load) begin
      c_d = '0;
      p_d = '0;
      k_d = '0;
      case (in_data_i.kind) inside
        KIND_RGB888, KIND_RGB565: addr_d = wr_start;
        KIND_SCAN: begin
          addr_d = scan_start;
          row_d  = row_last ? '0 : row_q + 1'b1;
          if (row_last) begin
            plane_d = (plane_q == PW'(BIT_PLANES - 1)) ? '0 : plane_q + 1'b1;
          end
        end
        default: addr_d = '0;
      endcase
    end else if (cmd_i.rmw_wr) begin
      if (c_q == LastColor) begin
        addr_d = addr_q + AW'(PlaneStep);
        c_d    = '0;
        p_d    = p_q + 1'b1;
      end else begin
        addr_d = addr_q + AW'(ColorStep);
        c_d    = c_q + 2'd1;
      end
    end else if (cmd_i.scan_rd) begin
      addr_d = addr_q + 1'b1;
      k_d    = k_q + 1'b1;
    end else if (cmd_i.clr_wr) begin
      addr_d = addr_q + 1'b1;
    end
  end

  // store access: read-modify-write of one plane byte, clear writes and scan reads
  always_comb begin
    set_bit   = cols_q[c_q][p_q];
    mask      = 8'd1 << bit_q;
    ram_re    = cmd_i.rmw_rd | cmd_i.scan_rd;
    ram_we    = cmd_i.rmw_wr | cmd_i.clr_wr;
    if (cmd_i.clr_wr) begin
      ram_wdata = '0;
    end else if (set_bit) begin
      ram_wdata = ram_rdata | mask;
    end else begin
      ram_wdata = ram_rdata & ~mask;
    end
  end

  ledscan_ram #(
    .WIDTH (8),
    .DEPTH (StoreBytes)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  // output register plus skid, read issued only when a slot is sure
  always_comb begin
    occ      = 2'(out_v_q) + 2'(skid_v_q) + 2'(pend_q);
    leave    = out_v_q & out_ready_i;
    out_free = !out_v_q || out_ready_i;

    arrive            = pend_item_q;
    arrive.shift_byte = ram_rdata;

    pend_item_d             = pend_item_q;
    pend_item_d.row_select  = meta_row_q;
    pend_item_d.plane_index = meta_plane_q;
    pend_item_d.on_time     = meta_ont_q;
    pend_item_d.shift_byte  = '0;
    pend_item_d.last_of_row = (k_q == KW'(GroupBytes - 1));

    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (out_free) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_d   = arrive;
        skid_v_d = pend_q;
      end else if (pend_q) begin
        out_d   = arrive;
        out_v_d = 1'b1;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (pend_q) begin
      skid_d   = arrive;
      skid_v_d = 1'b1;
    end
  end

  always_comb begin
    sts_o.coord_ok  = x_ok && y_ok;
    sts_o.rmw_last  = (c_q == LastColor) && (p_q == PW'(BIT_PLANES - 1));
    sts_o.scan_last = (k_q == KW'(GroupBytes - 1));
    sts_o.clr_last  = (addr_q == AW'(StoreBytes - 1));
    sts_o.can_issue = ((occ - 2'(leave)) < 2'd2);
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q   <= '0;
      c_q      <= '0;
      p_q      <= '0;
      k_q      <= '0;
      row_q    <= '0;
      plane_q  <= '0;
      base_q   <= BaseOnTimeReset;
      pend_q   <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      addr_q   <= addr_d;
      c_q      <= c_d;
      p_q      <= p_d;
      k_q      <= k_d;
      row_q    <= row_d;
      plane_q  <= plane_d;
      pend_q   <= cmd_i.scan_rd;
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cols_q       <= cols_d;
      bit_q        <= mx[2:0];
      meta_row_q   <= 4'(row_q);
      meta_plane_q <= 2'(plane_q);
      meta_ont_q   <= 19'(base_q) << plane_q;
    end
    if (cmd_i.scan_rd) begin
      pend_item_q <= pend_item_d;
    end
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

>>> src/rgb_led_panel_scan_driver_top.sv
`timescale 1ns / 1ps
// top level of the rgb led panel frame store and scan driver
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (base_on_time)
//
// pixel write: a read-modify-write of each plane byte, 3 * BIT_PLANES bytes
//   (12 by default), each read followed by its write back to the frame store
// out-of-panel write: taken and dropped, the frame store does not change
// scan: one byte per cycle from the store read port while the output stage
//   has room, 48 transactions per row group; the next item is taken once
//   the last read has been issued, bytes still staged drain behind it
// clear: one byte a cycle over the store, StoreBytes bytes (3072 by default)
// reset: the same clearing pass runs after reset, in_ready_o stays low until
//   it is done; configuration writes are taken at any time
module rgb_led_panel_scan_driver_top
  import ledscan_pkg::*;
#(
  parameter int unsigned PANEL_WIDTH  = 64,  // multiple of 8
  parameter int unsigned PANEL_HEIGHT = 32,  // even
  parameter int unsigned BIT_PLANES   = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // register write is always taken, software only writes while idle
  assign cfg_ready_o = 1'b1;

  // state machine: picks the sequence for each input transaction
  ledscan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (in_data_i.kind),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: frame store, address counters and output staging
  ledscan_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT),
    .BIT_PLANES   (BIT_PLANES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // a scan read only goes out when the output stage has room for its byte
  a_scan_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> sts.can_issue)
    else $error("scan read issued without output room");

  // at most one datapath operation per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.rmw_rd, cmd.rmw_wr, cmd.scan_rd, cmd.clr_wr}))
    else $error("overlapping datapath commands");

  // every plane byte read of a pixel write is followed by its write back
  a_rmw_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rmw_rd |=> cmd.rmw_wr)
    else $error("read-modify-write lost its write");

  // the store is untouched while a new transaction may be taken
  a_ready_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.rmw_wr || cmd.clr_wr || cmd.scan_rd))
    else $error("store busy while input ready");

endmodule

>>> bench/rgb_led_panel_scan_driver_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the rgb led panel frame store and scan driver
module rgb_led_panel_scan_driver_top_tb;
  import ledscan_pkg::*;

  // panel geometry, kept equal to the dut parameters below
  localparam int PanelW     = 64;
  localparam int PanelH     = 32;
  localparam int Planes     = 4;
  localparam int RowBytes   = PanelW / 8;
  localparam int GroupBytes = 3 * 2 * RowBytes;
  localparam int PlaneBytes = (PanelH / 2) * GroupBytes;
  localparam int StoreBytes = Planes * PlaneBytes;

  // idle time before an on-time write and at the end: the clearing pass is the longest job
  localparam int SettleCycles = StoreBytes + 128;
  localparam int PhaseItems   = 28;
  localparam int CfgPhases    = 5;
  localparam int MaxShown     = 10;
  localparam int MaxGap       = 17;

  // a directed scan whose whole row group can be typed in: one fill byte everywhere
  typedef struct packed {
    logic        known;
    logic [3:0]  row;
    logic [1:0]  plane;
    logic [18:0] ont;
    logic [7:0]  fill;
  } scan_note_t;

  typedef struct packed {
    in_item_t   item;
    scan_note_t note;
  } dir_entry_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  // note that travels with the input transaction currently offered
  scan_note_t  in_note;

  // shadow of the frame store, scan position and on-time register
  logic [7:0]  frame_mem [StoreBytes];
  logic [3:0]  scan_row_q;
  logic [1:0]  scan_plane_q;
  logic [15:0] on_base;

  // shift bytes the dut still owes, oldest first
  out_item_t   shift_q [$];

  dir_entry_t  dir_tab [$];

  int          fault_cnt;
  int          result_cnt;
  int          scan_cnt;
  int          write_cnt;
  int          offpanel_cnt;
  int          clear_cnt;
  int          cfg_cnt;

  // random idle state, one pair per side
  int          src_left;
  bit          src_calm;

  rgb_led_panel_scan_driver_top #(
    .PANEL_WIDTH (PanelW),
    .PANEL_HEIGHT(PanelH),
    .BIT_PLANES  (Planes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // hard stop in case a handshake never completes
  initial begin
    #20_000_000;
    $display("timeout: %0d shift bytes still owed", shift_q.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit on_panel(input logic signed [15:0] x, input logic signed [15:0] y);
    return x >= 0 && x < PanelW && y >= 0 && y < PanelH;
  endfunction

  // five bit channel to eight bits with the rounding constants
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return 8'((v * Exp5Mul + Exp5Add) >> 6);
  endfunction

  // sets or clears one bit per plane and color; x is mirrored before it is placed
  task automatic paint_pixel(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int mx;
    int byt;
    int grp;
    int half;
    int idx;
    logic [3:0] nib [3];
    if (on_panel(x, y)) begin
      mx  = PanelW - 1 - x;
      byt = RowBytes - 1 - mx / 8;
      // the upper half-row sits in the second slot of each color
      if (y >= PanelH / 2) begin
        grp  = y - PanelH / 2;
        half = 0;
      end else begin
        grp  = y;
        half = 1;
      end
      nib[0] = b[7:4];
      nib[1] = g[7:4];
      nib[2] = r[7:4];
      for (int p = 0; p < Planes; p++) begin
        for (int c = 0; c < 3; c++) begin
          idx = p * PlaneBytes + grp * GroupBytes + c * 2 * RowBytes + half * RowBytes + byt;
          frame_mem[idx][mx % 8] = nib[c][p];
        end
      end
    end
  endtask

  // applies one accepted input transaction to the shadow state and queues its shift bytes
  task automatic frame_model_accept(input in_item_t it);
    out_item_t   b;
    logic [18:0] ont;
    int          base;
    case (it.kind)
      KIND_RGB888: begin
        paint_pixel(it.pos_x, it.pos_y, it.red_in, it.green_in, it.blue_in);
      end
      KIND_RGB565: begin
        paint_pixel(it.pos_x, it.pos_y, widen5(it.packed_color[15:11]),
                    8'((it.packed_color[10:5] * Exp6Mul + Exp6Add) >> 6),
                    widen5(it.packed_color[4:0]));
      end
      KIND_CLEAR: begin
        // scan position is left alone
        foreach (frame_mem[i]) frame_mem[i] = '0;
      end
      default: begin
        ont  = {3'b000, on_base} << scan_plane_q;
        base = scan_plane_q * PlaneBytes + scan_row_q * GroupBytes;
        for (int k = 0; k < GroupBytes; k++) begin
          b.row_select  = scan_row_q;
          b.shift_byte  = frame_mem[base + k];
          b.plane_index = scan_plane_q;
          b.on_time     = ont;
          b.last_of_row = (k == GroupBytes - 1);
          shift_q.push_back(b);
        end
        if (scan_row_q == 4'(PanelH / 2 - 1)) begin
          scan_row_q   = '0;
          scan_plane_q = (scan_plane_q == 2'(Planes - 1)) ? 2'd0 : scan_plane_q + 2'd1;
        end else begin
          scan_row_q = scan_row_q + 4'd1;
        end
      end
    endcase
  endtask

  task automatic report(input string msg);
    fault_cnt++;
    if (fault_cnt <= MaxShown) $display("%s", msg);
  endtask

  // draws the idle cycles before the next transaction; calm stretches have none
  task automatic next_gap(inout int left, inout bit calm, output int gap);
    if (left == 0) begin
      left = $urandom_range(4, 30);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    gap = calm ? 0 : $urandom_range(0, MaxGap);
  endtask

  // offers one input transaction after a random gap and returns on the accepting edge
  task automatic send_item(input in_item_t it, input scan_note_t note);
    int gap;
    next_gap(src_left, src_calm, gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    in_note    <= note;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // waits until every owed byte has arrived, then lets a clear or write finish
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (shift_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly well-formed pixel writes and scans, some off-panel writes and clears
  task automatic build_random(output in_item_t it);
    int pick;
    pick            = $urandom_range(0, 99);
    it.pos_x        = 16'($urandom);
    it.pos_y        = 16'($urandom);
    it.red_in       = 8'($urandom);
    it.green_in     = 8'($urandom);
    it.blue_in      = 8'($urandom);
    it.packed_color = 16'($urandom);
    if (pick < 42) begin
      it.kind = KIND_SCAN;
    end else if (pick < 45) begin
      it.kind = KIND_CLEAR;
    end else begin
      it.kind = $urandom_range(0, 1) ? KIND_RGB565 : KIND_RGB888;
      if (pick < 88) begin
        it.pos_x = 16'($urandom_range(0, PanelW - 1));
        it.pos_y = 16'($urandom_range(0, PanelH - 1));
        // saturated colors now and then
        if (pick >= 83) begin
          it.red_in       = {8{1'($urandom_range(0, 1))}};
          it.green_in     = {8{1'($urandom_range(0, 1))}};
          it.blue_in      = {8{1'($urandom_range(0, 1))}};
          it.packed_color = {16{1'($urandom_range(0, 1))}};
        end
      end else if (pick < 94) begin
        // just past one edge of the panel
        it.pos_x = 16'($urandom_range(0, PanelW - 1));
        it.pos_y = 16'($urandom_range(0, PanelH - 1));
        case ($urandom_range(0, 3))
          0:       it.pos_x = -16'sd1;
          1:       it.pos_x = 16'(PanelW);
          2:       it.pos_y = -16'sd1;
          default: it.pos_y = 16'(PanelH);
        endcase
      end
    end
  endtask

  function automatic dir_entry_t px(input kind_e k, input int x, input int y, input int r,
                                    input int g, input int b, input int pc);
    dir_entry_t e;
    e                   = '0;
    e.item.kind         = k;
    e.item.pos_x        = 16'(x);
    e.item.pos_y        = 16'(y);
    e.item.red_in       = 8'(r);
    e.item.green_in     = 8'(g);
    e.item.blue_in      = 8'(b);
    e.item.packed_color = 16'(pc);
    return e;
  endfunction

  // scan of an empty store at plane zero with the reset on-time
  function automatic dir_entry_t blank_scan(input int row);
    dir_entry_t e;
    e            = px(KIND_SCAN, 0, 0, 0, 0, 0, 0);
    e.note.known = 1'b1;
    e.note.row   = 4'(row);
    e.note.plane = 2'd0;
    e.note.ont   = 19'(BaseOnTimeReset);
    e.note.fill  = 8'h00;
    return e;
  endfunction

  // watches all three channels at each edge: result check first, then prediction
  always @(posedge clk_i) begin : watch
    out_item_t want;
    int        first;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_cnt++;
        if (shift_q.size() == 0) begin
          report($sformatf("result %0d with nothing owed: row %0d byte %02h plane %0d",
                           result_cnt, out_data_o.row_select, out_data_o.shift_byte,
                           out_data_o.plane_index));
        end else begin
          want = shift_q.pop_front();
          if (want.row_select !== out_data_o.row_select ||
              want.shift_byte !== out_data_o.shift_byte ||
              want.plane_index !== out_data_o.plane_index ||
              want.on_time !== out_data_o.on_time ||
              want.last_of_row !== out_data_o.last_of_row) begin
            report($sformatf({"result %0d: expected row %0d byte %02h plane %0d on %0d last %0b,",
                              " got row %0d byte %02h plane %0d on %0d last %0b"},
                             result_cnt, want.row_select, want.shift_byte, want.plane_index,
                             want.on_time, want.last_of_row, out_data_o.row_select,
                             out_data_o.shift_byte, out_data_o.plane_index,
                             out_data_o.on_time, out_data_o.last_of_row));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        on_base = cfg_data_i;
        cfg_cnt++;
      end
      if (in_valid_i && in_ready_o) begin
        case (in_data_i.kind)
          KIND_SCAN:  scan_cnt++;
          KIND_CLEAR: clear_cnt++;
          default: begin
            if (on_panel(in_data_i.pos_x, in_data_i.pos_y)) write_cnt++;
            else offpanel_cnt++;
          end
        endcase
        first = shift_q.size();
        frame_model_accept(in_data_i);
        // rows typed into the table replace what the shadow predicts
        if (in_note.known) begin
          for (int k = first; k < shift_q.size(); k++) begin
            want             = shift_q[k];
            want.row_select  = in_note.row;
            want.shift_byte  = in_note.fill;
            want.plane_index = in_note.plane;
            want.on_time     = in_note.ont;
            shift_q[k]       = want;
          end
        end
      end
    end
  end

  // result side: random stall before each transaction
  initial begin : sink
    int gap;
    int left;
    bit calm;
    left = 0;
    calm = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      next_gap(left, calm, gap);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // input side: reset, directed table, then random phases at several on-times
  initial begin : source
    in_item_t    it;
    logic [15:0] cfg_list [CfgPhases];
    int          taken;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    in_note     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    scan_row_q   = '0;
    scan_plane_q = '0;
    on_base      = BaseOnTimeReset;
    src_left     = 0;
    src_calm     = 1'b0;
    fault_cnt    = 0;
    result_cnt   = 0;
    scan_cnt     = 0;
    write_cnt    = 0;
    offpanel_cnt = 0;
    clear_cnt    = 0;
    cfg_cnt      = 0;

    // empty store right after reset, row 0 of plane 0
    dir_tab.push_back(blank_scan(0));
    // corner pixels, both halves of row group 1
    dir_tab.push_back(px(KIND_RGB888, 0, 1, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_RGB888, 63, 17, 255, 255, 255, 0));
    // off-panel writes on every side and at the coordinate extremes
    dir_tab.push_back(px(KIND_RGB888, 64, 1, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_RGB888, -1, 1, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_RGB888, 3, 32, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_RGB888, 32767, -32768, 255, 255, 255, 65535));
    dir_tab.push_back(px(KIND_RGB888, -32768, 32767, 255, 255, 255, 65535));
    // rgb565 extremes and single channels
    dir_tab.push_back(px(KIND_RGB565, 1, 1, 0, 0, 0, 16'hFFFF));
    dir_tab.push_back(px(KIND_RGB565, 62, 17, 0, 0, 0, 16'hF800));
    dir_tab.push_back(px(KIND_RGB565, 10, 1, 0, 0, 0, 16'h07E0));
    // color fields of the other kind are ignored
    dir_tab.push_back(px(KIND_RGB565, 20, 17, 255, 255, 255, 16'h001F));
    dir_tab.push_back(px(KIND_RGB888, 30, 1, 8'h80, 8'h40, 8'h10, 16'hFFFF));
    dir_tab.push_back(px(KIND_RGB565, 31, 1, 255, 0, 255, 16'h8410));
    dir_tab.push_back(px(KIND_SCAN, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(px(KIND_RGB888, 7, 2, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_RGB565, 56, 18, 0, 0, 0, 16'h8410));
    // overwrite with black clears the bits again
    dir_tab.push_back(px(KIND_RGB888, 0, 2, 0, 0, 0, 0));
    dir_tab.push_back(px(KIND_RGB888, 7, 2, 0, 0, 0, 0));
    dir_tab.push_back(px(KIND_SCAN, 0, 0, 0, 0, 0, 0));
    // clear empties the store but the scan goes on at row 3
    dir_tab.push_back(px(KIND_RGB888, 40, 3, 255, 255, 255, 0));
    dir_tab.push_back(px(KIND_CLEAR, 0, 0, 255, 255, 255, 16'hFFFF));
    dir_tab.push_back(blank_scan(3));
    dir_tab.push_back(blank_scan(4));

    cfg_list[0] = 16'hFFFF;
    cfg_list[1] = 16'h0000;
    cfg_list[2] = 16'($urandom);
    cfg_list[3] = 16'h8000;
    cfg_list[4] = 16'($urandom);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the first transaction waits out the clearing pass after reset
    foreach (dir_tab[i]) send_item(dir_tab[i].item, dir_tab[i].note);

    for (int ph = 0; ph < CfgPhases; ph++) begin
      wait_idle();
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= cfg_list[ph];
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      cfg_valid_i <= 1'b0;
      // off-panel writes do nothing and are not counted
      taken = 0;
      while (taken < PhaseItems) begin
        build_random(it);
        send_item(it, '0);
        if (it.kind == KIND_SCAN || it.kind == KIND_CLEAR || on_panel(it.pos_x, it.pos_y))
          taken++;
      end
    end

    wait_idle();
    $display("covered %0d scans, %0d pixel writes, %0d off-panel writes, %0d clears",
             scan_cnt, write_cnt, offpanel_cnt, clear_cnt);
    $display("checked %0d shift bytes over %0d on-time settings, %0d faults",
             result_cnt, cfg_cnt + 1, fault_cnt);
    if (fault_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
